[rtl/mpcb_pkg.sv]
// Package for the two-channel pseudocolor max blend: payload structs,
// register index codes and arithmetic widths.
// No dependencies.
`default_nettype none

package mpcb_pkg;

  localparam int unsigned NUM_CH   = 2;
  localparam int unsigned NUM_COMP = 3;   // blue, green, red
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned TINT_W   = 27;
  localparam int unsigned COMP_W   = 9;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CNT_W    = 2;

  // scale * {0,sample}, window with offset, window * {0,tint}
  localparam int unsigned MUL_W  = SCALE_W + SAMPLE_W + 1;
  localparam int unsigned WIN_W  = MUL_W + 1;
  localparam int unsigned PROD_W = WIN_W + COMP_W + 1;
  // The product carries 24 fraction bits; the integer byte sits just above.
  localparam int unsigned PROD_FRAC = 24;

  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 5;

  typedef enum logic [2:0] {
    REG_SCALE_FIRST   = 3'd0,
    REG_OFFSET_FIRST  = 3'd1,
    REG_TINT_FIRST    = 3'd2,
    REG_SCALE_SECOND  = 3'd3,
    REG_OFFSET_SECOND = 3'd4,
    REG_TINT_SECOND   = 3'd5,
    REG_ALPHA_VALUE   = 3'd6,
    REG_CHANNELS_USED = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_first;
    logic [SAMPLE_W-1:0] sample_second;
  } pix_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] blue_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] red_byte;
    logic [BYTE_W-1:0] alpha_byte;
  } pix_out_t;

endpackage

`default_nettype wire

[rtl/multichannel_pseudocolor_max_blend.sv]
// Two-channel pseudocolor composite with per-component maximum, BGRA output.
// Depends on mpcb_pkg.
//
//   port group       direction  handshake                 payload
//   request in       in         in_valid_i / in_stall_o   in_data_i  (pix_in_t)
//   result out       out        out_valid_o / out_stall_i out_data_o (pix_out_t)
//   register access  in/out     psel/penable/pready       paddr/pwdata/prdata
//
// One request enters per cycle while in_stall_o is low; each result passes through four
// register stages (gain multiply, offset add, tint multiply,
// clamp and maximum).
// Every stage holds its own valid bit and only moves when the stage ahead frees up,
// so a stall on the output fills the pipe before in_stall_o rises.
// Reset clears the stage valid bits and loads the register defaults.
`default_nettype none

module multichannel_pseudocolor_max_blend (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire mpcb_pkg::pix_in_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output mpcb_pkg::pix_out_t               out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mpcb_pkg::APB_AW-1:0] paddr,
  input  wire logic [mpcb_pkg::APB_DW-1:0] pwdata,
  output logic      [mpcb_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);
  import mpcb_pkg::*;

  // ---------------- configuration registers ----------------
  logic [SCALE_W-1:0]  scale_q  [NUM_CH];
  logic [OFFSET_W-1:0] offset_q [NUM_CH];
  logic [TINT_W-1:0]   tint_q   [NUM_CH];
  logic [BYTE_W-1:0]   alpha_q;
  logic [CNT_W-1:0]    chan_q;
  reg_idx_e            reg_idx;
  logic                reg_wr;

  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q[0]  <= SCALE_W'(65536);
      scale_q[1]  <= SCALE_W'(65536);
      offset_q[0] <= '0;
      offset_q[1] <= '0;
      tint_q[0]   <= TINT_W'(67240192);
      tint_q[1]   <= TINT_W'(67240192);
      alpha_q     <= '1;
      chan_q      <= CNT_W'(2);
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_SCALE_FIRST:   scale_q[0]  <= pwdata[SCALE_W-1:0];
        REG_OFFSET_FIRST:  offset_q[0] <= pwdata[OFFSET_W-1:0];
        REG_TINT_FIRST:    tint_q[0]   <= pwdata[TINT_W-1:0];
        REG_SCALE_SECOND:  scale_q[1]  <= pwdata[SCALE_W-1:0];
        REG_OFFSET_SECOND: offset_q[1] <= pwdata[OFFSET_W-1:0];
        REG_TINT_SECOND:   tint_q[1]   <= pwdata[TINT_W-1:0];
        REG_ALPHA_VALUE:   alpha_q     <= pwdata[BYTE_W-1:0];
        REG_CHANNELS_USED: chan_q      <= pwdata[CNT_W-1:0];
        default:           chan_q      <= chan_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCALE_FIRST:   prdata = APB_DW'(scale_q[0]);
      REG_OFFSET_FIRST:  prdata = APB_DW'(offset_q[0]);
      REG_TINT_FIRST:    prdata = APB_DW'(tint_q[0]);
      REG_SCALE_SECOND:  prdata = APB_DW'(scale_q[1]);
      REG_OFFSET_SECOND: prdata = APB_DW'(offset_q[1]);
      REG_TINT_SECOND:   prdata = APB_DW'(tint_q[1]);
      REG_ALPHA_VALUE:   prdata = APB_DW'(alpha_q);
      REG_CHANNELS_USED: prdata = APB_DW'(chan_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------- datapath ----------------
  logic [SAMPLE_W-1:0]     sample [NUM_CH];
  logic [MUL_W-1:0]        mul_d  [NUM_CH];
  logic [MUL_W-1:0]        mul_q  [NUM_CH];
  logic [WIN_W-1:0]        win_d  [NUM_CH];
  logic [WIN_W-1:0]        win_q  [NUM_CH];
  logic [PROD_W-1:0]       prod_d [NUM_CH][NUM_COMP];
  logic [PROD_W-1:0]       prod_q [NUM_CH][NUM_COMP];
  logic [BYTE_W-1:0]       sat    [NUM_CH][NUM_COMP];
  logic [BYTE_W-1:0]       best   [NUM_COMP];
  pix_out_t                out_d;
  pix_out_t                out_q;

  // Clamp a Q.24 product to 0..255 and truncate.
  function automatic logic [BYTE_W-1:0] clamp_byte(input logic [PROD_W-1:0] p);
    logic [BYTE_W-1:0] r;
    if (p[PROD_W-1]) begin
      r = '0;
    end else if (|p[PROD_W-2:PROD_FRAC+BYTE_W]) begin
      r = '1;
    end else begin
      r = p[PROD_FRAC+BYTE_W-1:PROD_FRAC];
    end
    return r;
  endfunction

  assign sample[0] = in_data_i.sample_first;
  assign sample[1] = in_data_i.sample_second;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      mul_d[c] = MUL_W'($signed(scale_q[c]) * $signed({1'b0, sample[c]}));
      // The offset is Q.8 and the window Q.16, so it moves up by eight bits.
      win_d[c] = {mul_q[c][MUL_W-1], mul_q[c]}
               + {{(WIN_W-OFFSET_W-8){offset_q[c][OFFSET_W-1]}}, offset_q[c], 8'h00};
      for (int k = 0; k < NUM_COMP; k++) begin
        prod_d[c][k] = PROD_W'($signed(win_q[c])
                     * $signed({1'b0, tint_q[c][k*COMP_W +: COMP_W]}));
        sat[c][k]    = clamp_byte(prod_q[c][k]);
      end
    end
    for (int k = 0; k < NUM_COMP; k++) begin
      best[k] = sat[0][k];
      if (chan_q >= CNT_W'(2) && sat[1][k] > sat[0][k]) begin
        best[k] = sat[1][k];
      end
    end
    out_d.blue_byte  = best[0];
    out_d.green_byte = best[1];
    out_d.red_byte   = best[2];
    out_d.alpha_byte = alpha_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) mul_q  <= mul_d;
    if (rdy2 && v1_q)       win_q  <= win_d;
    if (rdy3 && v2_q)       prod_q <= prod_d;
    if (rdy4 && v3_q)       out_q  <= out_d;
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/mpcb_checker.sv]
// Port-level checks for the pseudocolor max blend, bound to the top level.
// Depends on mpcb_pkg and multichannel_pseudocolor_max_blend.
`default_nettype none

module mpcb_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire mpcb_pkg::pix_in_t           in_data_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire mpcb_pkg::pix_out_t          out_data_o,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [mpcb_pkg::APB_AW-1:0] paddr,
  input wire logic [mpcb_pkg::APB_DW-1:0] pwdata,
  input wire logic [mpcb_pkg::APB_DW-1:0] prdata,
  input wire logic                        pready
);
  import mpcb_pkg::*;

  // The input side only backs up once the whole pipe is full behind a stalled result.
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output is free");

  // A stalled request stays offered with the same pixel.
  a_in_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("stalled request changed");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("stalled result changed");

  // A written alpha value reads back at once.
  a_alpha_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr == APB_AW'(REG_ALPHA_VALUE * 4))
    |=> (paddr != $past(paddr)) || (prdata[BYTE_W-1:0] == $past(pwdata[BYTE_W-1:0])))
    else $error("alpha register read-back mismatch");

endmodule

bind multichannel_pseudocolor_max_blend mpcb_checker u_mpcb_checker (.*);

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the two-channel pseudocolor max blend: APB register
// programming, random pixel requests with random handshake gaps, scoreboard predictor.
// Depends on mpcb_pkg and multichannel_pseudocolor_max_blend.
`timescale 1ns / 100ps

import mpcb_pkg::*;

class blend_scoreboard;
  logic [SCALE_W-1:0]  gain  [NUM_CH];
  logic [OFFSET_W-1:0] bias  [NUM_CH];
  logic [TINT_W-1:0]   tint  [NUM_CH];
  logic [BYTE_W-1:0]   alpha;
  logic [CNT_W-1:0]    chans;
  pix_out_t            awaited [$];
  int unsigned         checked;
  int unsigned         mismatches;

  function new();
    for (int c = 0; c < NUM_CH; c++) begin
      gain[c] = SCALE_W'(65536);
      bias[c] = '0;
      tint[c] = {9'd256, 9'd256, 9'd256};
    end
    alpha      = 8'hFF;
    chans      = CNT_W'(2);
    checked    = 0;
    mismatches = 0;
  endfunction

  // Bits above a register's width are dropped, as the hardware does.
  function void write_reg(reg_idx_e idx, logic [APB_DW-1:0] v);
    case (idx)
      REG_SCALE_FIRST:   gain[0] = v[SCALE_W-1:0];
      REG_OFFSET_FIRST:  bias[0] = v[OFFSET_W-1:0];
      REG_TINT_FIRST:    tint[0] = v[TINT_W-1:0];
      REG_SCALE_SECOND:  gain[1] = v[SCALE_W-1:0];
      REG_OFFSET_SECOND: bias[1] = v[OFFSET_W-1:0];
      REG_TINT_SECOND:   tint[1] = v[TINT_W-1:0];
      REG_ALPHA_VALUE:   alpha   = v[BYTE_W-1:0];
      REG_CHANNELS_USED: chans   = v[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // The product carries 24 fraction bits; positive values below 255.0 truncate.
  function logic [BYTE_W-1:0] saturate(longint win, logic [COMP_W-1:0] t);
    longint tl;
    longint p;
    longint lim;
    tl  = t;
    p   = win * tl;
    lim = 64'sd255 <<< PROD_FRAC;
    if (p <= 0) return '0;
    if (p >= lim) return 8'hFF;
    p = p >>> PROD_FRAC;
    return p[BYTE_W-1:0];
  endfunction

  // Returns {red, green, blue} of one channel.
  function logic [3*BYTE_W-1:0] shade(int ch, logic [SAMPLE_W-1:0] s);
    longint g;
    longint o;
    longint x;
    longint win;
    logic [3*BYTE_W-1:0] rgb;
    g   = $signed(gain[ch]);
    o   = $signed(bias[ch]);
    x   = s;
    win = g * x + o * 256;
    for (int k = 0; k < NUM_COMP; k++)
      rgb[k*BYTE_W +: BYTE_W] = saturate(win, tint[ch][k*COMP_W +: COMP_W]);
    return rgb;
  endfunction

  function pix_out_t blend(pix_in_t px);
    logic [3*BYTE_W-1:0] a;
    logic [3*BYTE_W-1:0] b;
    pix_out_t res;
    a = shade(0, px.sample_first);
    // A channel count of zero or one leaves the second channel out entirely.
    if (chans >= 2) begin
      b = shade(1, px.sample_second);
      for (int k = 0; k < NUM_COMP; k++)
        if (b[k*BYTE_W +: BYTE_W] > a[k*BYTE_W +: BYTE_W])
          a[k*BYTE_W +: BYTE_W] = b[k*BYTE_W +: BYTE_W];
    end
    res.blue_byte  = a[BYTE_W-1:0];
    res.green_byte = a[2*BYTE_W-1:BYTE_W];
    res.red_byte   = a[3*BYTE_W-1:2*BYTE_W];
    res.alpha_byte = alpha;
    return res;
  endfunction

  function void note_request(pix_in_t px);
    awaited.push_back(blend(px));
  endfunction

  function void check_result(pix_out_t got);
    pix_out_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected pixel %h with no request outstanding.", got);
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (got.blue_byte !== want.blue_byte || got.green_byte !== want.green_byte ||
        got.red_byte !== want.red_byte || got.alpha_byte !== want.alpha_byte) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Pixel %0d mismatch: expected B %0d G %0d R %0d A %0d, got B %0d G %0d R %0d A %0d",
                 checked, want.blue_byte, want.green_byte, want.red_byte, want.alpha_byte,
                 got.blue_byte, got.green_byte, got.red_byte, got.alpha_byte);
    end
  endfunction
endclass

module testbench;
  localparam int unsigned CYCLE_LIMIT        = 200000;
  localparam int unsigned SETTLE_CYCLES      = 8;
  localparam int unsigned RANDOM_SETTINGS    = 12;
  localparam int unsigned PIXELS_PER_SETTING = 84;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  pix_in_t           in_data   = '0;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic              in_stall;
  logic              out_valid;
  pix_out_t          out_data;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles         = 0;
  int unsigned requests       = 0;
  int unsigned settings_done  = 0;

  blend_scoreboard board;

  always #10 clk_i = ~clk_i;

  multichannel_pseudocolor_max_blend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with results outstanding.", cycles);
      $display("FAIL multichannel_pseudocolor_max_blend");
      $finish;
    end
  end

  // Result side: check what was taken at this edge, then pick the next stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        board.check_result(out_data);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_pixel(logic [SAMPLE_W-1:0] first, logic [SAMPLE_W-1:0] second);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid              <= 1'b1;
    in_data.sample_first  <= first;
    in_data.sample_second <= second;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    board.note_request('{sample_first: first, sample_second: second});
    requests++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [APB_DW-1:0] g0, logic [APB_DW-1:0] o0,
                              logic [APB_DW-1:0] t0, logic [APB_DW-1:0] g1,
                              logic [APB_DW-1:0] o1, logic [APB_DW-1:0] t1,
                              logic [APB_DW-1:0] a, logic [APB_DW-1:0] n);
    wait_idle();
    write_reg(REG_SCALE_FIRST, g0);
    write_reg(REG_OFFSET_FIRST, o0);
    write_reg(REG_TINT_FIRST, t0);
    write_reg(REG_SCALE_SECOND, g1);
    write_reg(REG_OFFSET_SECOND, o1);
    write_reg(REG_TINT_SECOND, t1);
    write_reg(REG_ALPHA_VALUE, a);
    write_reg(REG_CHANNELS_USED, n);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    settings_done++;
  endtask

  // Half of the writes carry random bits above the register width.
  function automatic logic [APB_DW-1:0] with_junk(logic [APB_DW-1:0] field, int w);
    return ($urandom_range(1) ? ($urandom() << w) : '0) | field;
  endfunction

  function automatic logic [APB_DW-1:0] rand_gain();
    logic [SCALE_W-1:0] g;
    case ($urandom_range(5))
      0:       g = {1'b1, {(SCALE_W-1){1'b0}}};
      1:       g = {1'b0, {(SCALE_W-1){1'b1}}};
      2:       g = SCALE_W'($urandom_range(2047)) - SCALE_W'(1024);
      3, 4:    g = SCALE_W'($urandom_range(600, 1));
      default: g = SCALE_W'($urandom());
    endcase
    return with_junk(g, SCALE_W);
  endfunction

  function automatic logic [APB_DW-1:0] rand_offset();
    logic [OFFSET_W-1:0] o;
    case ($urandom_range(5))
      0:       o = {1'b1, {(OFFSET_W-1){1'b0}}};
      1:       o = {1'b0, {(OFFSET_W-1){1'b1}}};
      2:       o = '0;
      default: o = OFFSET_W'($urandom_range(153600)) - OFFSET_W'(76800);
    endcase
    return with_junk(o, OFFSET_W);
  endfunction

  function automatic logic [APB_DW-1:0] rand_tint();
    logic [TINT_W-1:0] t;
    case ($urandom_range(5))
      0:       t = '1;
      1:       t = '0;
      2:       t = {9'd256, 9'd256, 9'd256};
      default: t = TINT_W'($urandom());
    endcase
    return with_junk(t, TINT_W);
  endfunction

  // Small samples keep coarse gains out of saturation.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return SAMPLE_W'($urandom_range(1023));
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 20;
    recv_stall_pct = 53;

    // Reset values: unit gain and tint, so each byte equals the larger sample up to 255.
    push_pixel(16'd0, 16'd0);
    push_pixel(16'hFFFF, 16'hFFFF);
    push_pixel(16'd1, 16'd0);
    push_pixel(16'd0, 16'd1);
    push_pixel(16'd254, 16'd100);
    push_pixel(16'd255, 16'd256);
    push_pixel(16'hAAAA, 16'h5555);
    push_pixel(16'h5555, 16'hAAAA);

    // Extreme gains and offsets, full tint on the first channel, and a channel count of three.
    program_regs(32'h0080_0000, 32'h0007_FFFF, 32'h07FF_FFFF,
                 32'h007F_FFFF, 32'h0008_0000, {9'd511, 9'd256, 9'd1},
                 32'h0000_0000, 32'd3);
    push_pixel(16'd0, 16'd0);
    push_pixel(16'hFFFF, 16'hFFFF);
    push_pixel(16'd1, 16'd1);
    push_pixel(16'hFFFF, 16'd0);

    // Single channel: the second sample must have no effect.
    program_regs(32'h0000_0100, 32'h000F_F600, {9'd1, 9'd511, 9'd256},
                 32'h007F_FFFF, 32'h0007_FFFF, 32'h07FF_FFFF,
                 32'h0000_00A5, 32'd1);
    push_pixel(16'd0, 16'hFFFF);
    push_pixel(16'd2560, 16'd0);
    push_pixel(16'hFFFF, 16'd12345);

    // A channel count of zero behaves like one; a negative gain with a positive offset.
    program_regs(32'h00FF_FF00, 32'h0000_C800, {9'd256, 9'd128, 9'd0},
                 32'h007F_FFFF, 32'h0007_FFFF, 32'h07FF_FFFF,
                 32'h0000_005A, 32'd0);
    push_pixel(16'd100, 16'hFFFF);
    push_pixel(16'hFFFF, 16'd0);

    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      wait_idle();
      case (s / 4)
        0: begin
          send_gap_pct   = 20;
          recv_stall_pct = 53;
        end
        1: begin
          send_gap_pct   = 53;
          recv_stall_pct = 20;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      program_regs(rand_gain(), rand_offset(), rand_tint(),
                   rand_gain(), rand_offset(), rand_tint(),
                   with_junk(BYTE_W'($urandom()), BYTE_W),
                   with_junk(CNT_W'($urandom_range(3)), CNT_W));
      repeat (PIXELS_PER_SETTING) push_pixel(rand_sample(), rand_sample());
    end

    wait_idle();
    if (board.awaited.size() != 0) begin
      $display("%0d expected pixels never arrived.", board.awaited.size());
      board.mismatches += board.awaited.size();
    end
    $display("Sent %0d pixel requests under %0d register settings; %0d results checked.",
             requests, settings_done, board.checked);
    $display("Settings spanned one and two channels, extreme gains, offsets and tints.");
    if (board.mismatches == 0) begin
      $display("PASS multichannel_pseudocolor_max_blend");
    end else begin
      $display("%0d mismatches in total.", board.mismatches);
      $display("FAIL multichannel_pseudocolor_max_blend");
    end
    $finish;
  end
endmodule
